/* sv/gqp_pkg.sv */
// shared types, constants and codes for the gray quantize and pack core
`default_nettype none

package gqp_pkg;

    // luma weights, q16
    localparam logic [14:0] W_RED   = 15'd19595;
    localparam logic [15:0] W_GREEN = 16'd38470;
    localparam logic [12:0] W_BLUE  = 13'd7471;

    // widest row in pixels
    localparam logic [12:0] MAX_WIDTH = 13'd4096;

    // register indexes on the config channel
    localparam logic [1:0] CFG_DEPTH_SELECT   = 2'd0;
    localparam logic [1:0] CFG_ROW_WIDTH      = 2'd1;
    localparam logic [1:0] CFG_SOURCE_IS_GRAY = 2'd2;

    // depth select codes
    localparam logic [1:0] DEPTH_1BIT = 2'd0;
    localparam logic [1:0] DEPTH_4BIT = 2'd1;
    localparam logic [1:0] DEPTH_8BIT = 2'd2;

    // reset values of the config registers
    localparam logic [1:0]  DEPTH_SELECT_RST = DEPTH_8BIT;
    localparam logic [12:0] ROW_WIDTH_RST    = 13'd1;

    typedef struct packed {
        logic [1:0]  depth_select;
        logic [12:0] row_width;
        logic        source_is_gray;
    } gqp_cfg_t;

    // gray level handed from the luma pipe to the packer
    typedef struct packed {
        logic       valid;
        logic [7:0] gray;
    } gqp_gray_t;

endpackage

`default_nettype wire

/* sv/gqp_luma.sv */
// input register, luma products and gray level register
`default_nettype none

module gqp_luma (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         red,
    input  wire logic [7:0]         green,
    input  wire logic [7:0]         blue,
    input  wire logic               source_is_gray,
    output gqp_pkg::gqp_gray_t      gray_out,
    input  wire logic               gray_ready
);

    logic        pix_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;

    logic        prod_valid_reg;
    logic [22:0] prod_r_reg;
    logic [23:0] prod_g_reg;
    logic [20:0] prod_b_reg;
    logic [7:0]  red_pass_reg;

    logic        gray_valid_reg;
    logic [7:0]  gray_reg;

    logic        adv_gray;
    logic        adv_prod;
    logic        adv_pix;
    logic [22:0] prod_r_next;
    logic [23:0] prod_g_next;
    logic [20:0] prod_b_next;
    logic [24:0] luma_sum;
    logic [8:0]  luma;
    logic [7:0]  gray_next;

    assign adv_gray = !gray_valid_reg || gray_ready;
    assign adv_prod = !prod_valid_reg || adv_gray;
    assign adv_pix  = !pix_valid_reg || adv_prod;
    assign in_ready = adv_pix;

    assign prod_r_next = 23'(gqp_pkg::W_RED) * 23'(red_reg);
    assign prod_g_next = 24'(gqp_pkg::W_GREEN) * 24'(green_reg);
    assign prod_b_next = 21'(gqp_pkg::W_BLUE) * 21'(blue_reg);

    assign luma_sum = 25'(prod_r_reg) + 25'(prod_g_reg) + 25'(prod_b_reg);
    assign luma     = luma_sum[24:16];

    always_comb
    begin
        if (source_is_gray)
        begin
            gray_next = red_pass_reg;
        end
        else if (luma > 9'd255)
        begin
            gray_next = 8'd255;
        end
        else
        begin
            gray_next = luma[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            gray_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_pix)
            begin
                pix_valid_reg <= in_valid;
            end
            if (adv_prod)
            begin
                prod_valid_reg <= pix_valid_reg;
            end
            if (adv_gray)
            begin
                gray_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_pix && in_valid)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
        end
        if (adv_prod && pix_valid_reg)
        begin
            prod_r_reg   <= prod_r_next;
            prod_g_reg   <= prod_g_next;
            prod_b_reg   <= prod_b_next;
            red_pass_reg <= red_reg;
        end
        if (adv_gray && prod_valid_reg)
        begin
            gray_reg <= gray_next;
        end
    end

    assign gray_out.valid = gray_valid_reg;
    assign gray_out.gray  = gray_reg;

endmodule

`default_nettype wire

/* sv/gqp_pack.sv */
// palette quantizer, bit packer, row padding and output register
`default_nettype none

module gqp_pack (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gqp_pkg::gqp_gray_t gray_in,
    output logic                    gray_ready,
    input  wire logic [1:0]         depth_select,
    input  wire logic [12:0]        row_width,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    row_last
);

    logic [11:0] column_count_reg;
    logic [7:0]  pack_acc_reg;
    logic [2:0]  bits_filled_reg;
    logic [1:0]  row_bytes_mod4_reg;
    logic [1:0]  pads_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        row_last_reg;

    logic [3:0]  bpp;
    logic [7:0]  idx;
    logic [8:0]  round_sum;
    logic [16:0] recip_prod;
    logic [3:0]  room;
    logic [7:0]  acc_or;
    logic        full;
    logic [3:0]  bits_sum;
    logic [7:0]  acc_next;
    logic [12:0] eff_width;
    logic        row_end;
    logic        out_free;
    logic        take;

    // nearest palette index; 4 bit levels are 17 apart, so round(g / 17)
    assign round_sum  = {1'b0, gray_in.gray} + 9'd8;
    assign recip_prod = 17'(round_sum) * 17'd241;

    always_comb
    begin
        case (depth_select)
            gqp_pkg::DEPTH_1BIT:
            begin
                bpp = 4'd1;
                idx = {7'd0, gray_in.gray[7]};
            end
            gqp_pkg::DEPTH_4BIT:
            begin
                bpp = 4'd4;
                idx = {3'd0, recip_prod[16:12]};
            end
            default:
            begin
                bpp = 4'd8;
                idx = gray_in.gray;
            end
        endcase
    end

    // msb-first packing; an index that overflows the room keeps its high bits
    assign room     = 4'd8 - {1'b0, bits_filled_reg};
    assign full     = (bpp >= room);
    assign bits_sum = {1'b0, bits_filled_reg} + bpp;

    always_comb
    begin
        if (full)
        begin
            acc_or = idx >> (bpp - room);
        end
        else
        begin
            acc_or = idx << (room - bpp);
        end
    end

    assign acc_next = pack_acc_reg | acc_or;

    always_comb
    begin
        if (row_width == 13'd0)
        begin
            eff_width = 13'd1;
        end
        else if (row_width > gqp_pkg::MAX_WIDTH)
        begin
            eff_width = gqp_pkg::MAX_WIDTH;
        end
        else
        begin
            eff_width = row_width;
        end
    end

    assign row_end    = ({1'b0, column_count_reg} + 13'd1) >= eff_width;
    assign out_free   = !out_valid_reg || out_ready;
    assign gray_ready = (pads_reg == 2'd0) && out_free;
    assign take       = gray_in.valid && gray_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= '0;
            pack_acc_reg       <= '0;
            bits_filled_reg    <= '0;
            row_bytes_mod4_reg <= '0;
            pads_reg           <= '0;
            out_valid_reg      <= 1'b0;
            out_byte_reg       <= '0;
            row_last_reg       <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (full || row_end)
                begin
                    out_valid_reg   <= 1'b1;
                    out_byte_reg    <= acc_next;
                    row_last_reg    <= row_end && (row_bytes_mod4_reg == 2'd3);
                    pack_acc_reg    <= '0;
                    bits_filled_reg <= '0;
                end
                else
                begin
                    pack_acc_reg    <= acc_next;
                    bits_filled_reg <= bits_sum[2:0];
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                if (row_end)
                begin
                    column_count_reg   <= '0;
                    row_bytes_mod4_reg <= '0;
                    pads_reg           <= 2'd3 - row_bytes_mod4_reg;
                end
                else
                begin
                    column_count_reg <= column_count_reg + 12'd1;
                    if (full)
                    begin
                        row_bytes_mod4_reg <= row_bytes_mod4_reg + 2'd1;
                    end
                end
            end
            else if ((pads_reg != 2'd0) && out_free)
            begin
                // zero padding up to the 4 byte row boundary
                out_valid_reg <= 1'b1;
                out_byte_reg  <= 8'd0;
                row_last_reg  <= (pads_reg == 2'd1);
                pads_reg      <= pads_reg - 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign row_last  = row_last_reg;

endmodule

`default_nettype wire

/* sv/gray_quantize_pack_core.sv */
// top level of the gray quantize and pack core
//
//  channel  | signals                               | direction | carries
//  ---------+---------------------------------------+-----------+---------------------------
//  s_axis   | tvalid tready tdata[23:0]             | in        | one rgb pixel per transaction
//  m_axis   | tvalid tready tdata[7:0] tlast        | out       | packed index or pad byte
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data| in        | register write
//
// one pixel per cycle is taken while no stage stalls; a byte leaves after its last pixel
// has passed the input register, product register, gray register and output register
// a row end adds up to 3 zero pad bytes; the packer takes no gray level while it
// sends them, so s_axis stalls once the three stages ahead of it are full
// output stalls back-pressure the pipe stage by stage; config writes are always taken
// reset clears all valid bits, the packer and the config registers (8 bit, width 1, rgb)
`default_nettype none

module gray_quantize_pack_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // pixel in
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    // byte out
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte [7:0]
    output logic             m_axis_tlast,   // row_last
    // register writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);

    gqp_pkg::gqp_cfg_t  cfg_reg;
    gqp_pkg::gqp_gray_t gray_bus;
    logic               gray_ready;

    assign cfg_ready = 1'b1;

    // config registers; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_select   <= gqp_pkg::DEPTH_SELECT_RST;
            cfg_reg.row_width      <= gqp_pkg::ROW_WIDTH_RST;
            cfg_reg.source_is_gray <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gqp_pkg::CFG_DEPTH_SELECT:   cfg_reg.depth_select   <= cfg_data[1:0];
                gqp_pkg::CFG_ROW_WIDTH:      cfg_reg.row_width      <= cfg_data;
                gqp_pkg::CFG_SOURCE_IS_GRAY: cfg_reg.source_is_gray <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // luma pipe: pixel register, weighted products, gray level
    gqp_luma u_luma (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .red            (s_axis_tdata[7:0]),
        .green          (s_axis_tdata[15:8]),
        .blue           (s_axis_tdata[23:16]),
        .source_is_gray (cfg_reg.source_is_gray),
        .gray_out       (gray_bus),
        .gray_ready     (gray_ready)
    );

    // quantize to the palette, pack msb first, pad each row to a multiple of 4 bytes
    gqp_pack u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .gray_in      (gray_bus),
        .gray_ready   (gray_ready),
        .depth_select (cfg_reg.depth_select),
        .row_width    (cfg_reg.row_width),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .row_last     (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* sv/gqp_checker.sv */
// port level checks for the gray quantize and pack core
`default_nettype none

module gqp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready
);

    logic [1:0] row_bytes_reg;
    logic       out_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // bytes sent in the current row, modulo 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= '0;
        end
        else if (out_xfer)
        begin
            row_bytes_reg <= m_axis_tlast ? 2'd0 : row_bytes_reg + 2'd1;
        end
    end

    // a stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("output byte changed while stalled");

    // every row closes on a 4 byte boundary
    a_row_align: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && m_axis_tlast) |-> (row_bytes_reg == 2'd3))
        else $error("row not padded to 4 bytes");

    // an empty output register never holds back pixels
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("pixel input stalled with empty output");

    // register writes are always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind gray_quantize_pack_core gqp_checker u_gqp_checker (.*);

`default_nettype wire
